// File: hw/rtl/spfa_pkg.sv
package spfa_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned ExpW  = 8;
  localparam int unsigned FracW = 23;
  localparam int unsigned ManW  = 25;
  localparam int unsigned ShW   = 5;

  typedef struct packed {
    logic             bypass;
    logic [WordW-1:0] bypass_val;
    logic             sub;
    logic             sign;
    logic [ExpW-1:0]  expo;
    logic [ManW-1:0]  ma;
    logic [ManW-1:0]  mb;
  } align_t;

  typedef struct packed {
    logic             bypass;
    logic [WordW-1:0] bypass_val;
    logic             sub;
    logic             zero;
    logic             sign;
    logic [ExpW-1:0]  expo;
    logic [ManW-1:0]  man;
  } arith_t;

  function automatic logic [ShW-1:0] lead_zeros(input logic [23:0] m);
    logic [ShW-1:0] n;
    logic           found;
    n = '0;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found && m[i]) begin
        found = 1'b1;
        n = ShW'(23 - i);
      end
    end
    return n;
  endfunction

endpackage

// File: hw/rtl/single_precision_float_adder_top.sv
// channel | ports                          | direction
// in      | in_valid in_stall in_operand_* | request in
// out     | out_valid out_stall out_sum_bits| request out
// three register stages: align, add/subtract, normalise
// one request per cycle sustained while out_stall stays low
// rst_n clears the valid bits only
// a stall freezes a stage only when its successor is full and stalled
module single_precision_float_adder_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [spfa_pkg::WordW-1:0]   in_operand_a,
  input  logic [spfa_pkg::WordW-1:0]   in_operand_b,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [spfa_pkg::WordW-1:0]   out_sum_bits
);
  spfa_pkg::align_t           al_nxt, al_r;
  spfa_pkg::arith_t           ar_nxt, ar_r;
  logic [spfa_pkg::WordW-1:0] res_nxt, res_r;
  logic v1_r, v2_r, v3_r, en1, en2, en3;

  spfa_align u_align (.a(in_operand_a), .b(in_operand_b), .al(al_nxt));
  spfa_arith u_arith (.al(al_r), .ar(ar_nxt));
  spfa_norm  u_norm  (.ar(ar_r), .res(res_nxt));

  assign en3 = !v3_r || !out_stall;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_stall = !en1;
  assign out_valid = v3_r;
  assign out_sum_bits = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) al_r <= al_nxt;
    if (en2) ar_r <= ar_nxt;
    if (en3) res_r <= res_nxt;
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sum_bits))
    else $error("result changed under stall");
  a_move: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !v3_r |=> v3_r)
    else $error("stage two lost a request");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v1_r && v2_r && v3_r)
    else $error("stall with an empty stage");
endmodule

// File: hw/rtl/spfa_align.sv
module spfa_align (
  input  logic [spfa_pkg::WordW-1:0] a,
  input  logic [spfa_pkg::WordW-1:0] b,
  output spfa_pkg::align_t           al
);
  logic [spfa_pkg::ExpW-1:0] ea, eb, d;
  logic [spfa_pkg::ManW-1:0] ma, mb, sm;
  logic                      a_zero, b_zero, a_lt;

  always_comb begin
    ea = a[30:23];
    eb = b[30:23];
    a_zero = (ea == '0) && (a[spfa_pkg::FracW-1:0] == '0);
    b_zero = (eb == '0) && (b[spfa_pkg::FracW-1:0] == '0);
    a_lt = ea < eb;
    ma = {2'b01, a[spfa_pkg::FracW-1:0]};
    mb = {2'b01, b[spfa_pkg::FracW-1:0]};
    d = a_lt ? (eb - ea) : (ea - eb);
    sm = (d >= 8'd32) ? '0 : ((a_lt ? ma : mb) >> d[4:0]);
    al.bypass = a_zero || b_zero;
    al.bypass_val = a_zero ? b : a;
    al.sub = a[31] != b[31];
    al.sign = a[31];
    al.expo = a_lt ? eb : ea;
    al.ma = a_lt ? sm : ma;
    al.mb = a_lt ? mb : sm;
  end
endmodule

// File: hw/rtl/spfa_arith.sv
module spfa_arith (
  input  spfa_pkg::align_t al,
  output spfa_pkg::arith_t ar
);
  always_comb begin
    ar.bypass = al.bypass;
    ar.bypass_val = al.bypass_val;
    ar.sub = al.sub;
    ar.zero = al.sub && (al.ma == al.mb);
    ar.sign = al.sign;
    ar.expo = al.expo;
    if (!al.sub) begin
      ar.man = al.ma + al.mb;
    end else if (al.mb > al.ma) begin
      ar.man = al.mb - al.ma;
      ar.sign = ~al.sign;
    end else begin
      ar.man = al.ma - al.mb;
    end
  end
endmodule

// File: hw/rtl/spfa_norm.sv
module spfa_norm (
  input  spfa_pkg::arith_t           ar,
  output logic [spfa_pkg::WordW-1:0] res
);
  logic [spfa_pkg::ShW-1:0]  lz;
  logic [spfa_pkg::ExpW:0]   e9;
  logic [23:0]               m;

  always_comb begin
    lz = spfa_pkg::lead_zeros(ar.man[23:0]);
    e9 = '0;
    m = '0;
    if (ar.bypass) begin
      res = ar.bypass_val;
    end else if (!ar.sub) begin
      if (ar.man[24]) begin
        e9 = {1'b0, ar.expo} + 9'd1;
        m = ar.man[24:1];
      end else begin
        e9 = {1'b0, ar.expo};
        m = ar.man[23:0];
      end
      res = {ar.sign, e9[7:0], m[22:0]};
    end else if (ar.zero || ({1'b0, ar.expo} < {4'd0, lz})) begin
      res = '0;
    end else begin
      m = ar.man[23:0] << lz;
      e9 = {1'b0, ar.expo} - {4'd0, lz};
      res = {ar.sign, e9[7:0], m[22:0]};
    end
  end
endmodule

// File: tb/sum_checker.sv
`timescale 1ns / 100ps

module sum_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_sum_bits,
  output int          fail_count,
  output int          pending_sums,
  output int          sums_seen
);

  localparam logic [31:0] ExpMask  = 32'h7F80_0000;
  localparam logic [31:0] FracMask = 32'h007F_FFFF;
  localparam logic [31:0] Hidden   = 32'h0080_0000;

  logic [31:0] sum_queue[$];

  function automatic logic [31:0] truncating_sum(input logic [31:0] a, input logic [31:0] b);
    logic        sa, sb, s;
    logic [31:0] ea, eb, ma, mb, e, m;
    sa = a[31];
    sb = b[31];
    ea = (a & ExpMask) >> 23;
    eb = (b & ExpMask) >> 23;
    if (ea == 0 && (a & FracMask) == 0) return b;
    if (eb == 0 && (b & FracMask) == 0) return a;
    ma = (a & FracMask) | Hidden;
    mb = (b & FracMask) | Hidden;
    if (ea < eb) begin
      ma = (eb - ea >= 32) ? 32'd0 : ma >> (eb - ea);
      e = eb;
    end else begin
      mb = (ea - eb >= 32) ? 32'd0 : mb >> (ea - eb);
      e = ea;
    end
    if (sa == sb) begin
      s = sa;
      m = ma + mb;
      if (m[24]) begin
        m = m >> 1;
        e = e + 1;
      end
    end else begin
      if (ma == mb) return 32'd0;
      if (mb > ma) begin
        s = sb;
        m = mb - ma;
      end else begin
        s = sa;
        m = ma - mb;
      end
      while (!m[23]) begin
        if (e == 0) return 32'd0;
        m = m << 1;
        e = e - 1;
      end
    end
    return {s, e[7:0], m[22:0]};
  endfunction

  assign pending_sums = sum_queue.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      fail_count <= 0;
      sums_seen <= 0;
    end else begin
      if (in_valid && !in_stall)
        sum_queue.push_back(truncating_sum(in_operand_a, in_operand_b));
      if (out_valid && !out_stall) begin
        sums_seen <= sums_seen + 1;
        if (sum_queue.size() == 0) begin
          $display("%0t: unexpected sum, expected none, actual %h", $time, out_sum_bits);
          fail_count <= fail_count + 1;
        end else begin
          if (sum_queue[0] !== out_sum_bits) begin
            $display("%0t: sum mismatch, expected %h, actual %h", $time, sum_queue[0],
                     out_sum_bits);
            fail_count <= fail_count + 1;
          end
          void'(sum_queue.pop_front());
        end
      end
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_operand_a = '0;
  logic [31:0] in_operand_b = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_sum_bits;
  int          fail_count, pending_sums, sums_seen;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_off = 1'b0;
  int          sent = 0;

  always #4 clk = ~clk;

  single_precision_float_adder_top u_top (.*);

  sum_checker u_chk (.*);

  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0: w[30:0] = '0;
      1: w[30:23] = '0;
      2: w[30:23] = 8'hFF;
      3: w[30:23] = 8'd127 + 8'($urandom_range(0, 6)) - 8'd3;
      4: w[30:23] = 8'($urandom_range(0, 3));
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_pair(input logic [31:0] a, input logic [31:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // receiver stall process
  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    logic [31:0] a, b;
    logic [31:0] d_a[$], d_b[$];
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    d_a = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000,
            32'h4000_0000, 32'h7F7F_FFFF, 32'h7F80_0000, 32'h7FFF_FFFF, 32'h0000_0001,
            32'h0080_0000, 32'h3F80_0000, 32'h3F80_0001, 32'hFFFF_FFFF, 32'h4B80_0000,
            32'h3F80_0000, 32'h0000_0003, 32'h5F80_0000, 32'h3FC0_0000};
    d_b = '{32'h4049_0FDB, 32'hC000_0000, 32'h0000_0000, 32'hBF80_0000, 32'h3F80_0000,
            32'hBF80_0001, 32'h7F7F_FFFF, 32'h7F80_0000, 32'hFFFF_FFFF, 32'h8000_0002,
            32'h8000_0001, 32'h2F80_0000, 32'hBF80_0000, 32'h7FFF_FFFF, 32'h3380_0000,
            32'h3300_0000, 32'h8000_0001, 32'h0080_0000, 32'hBFBF_FFFF};
    foreach (d_a[i]) send_pair(d_a[i], d_b[i]);
    for (int k = 0; k < 1750; k++) begin
      case (k / 350)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 54; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 54; end
        3: begin send_idle_pct = 21; stall_pct = 21; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      a = pick_word();
      b = pick_word();
      if ($urandom_range(0, 3) == 0) begin
        b[30:23] = a[30:23] + 8'($urandom_range(0, 2)) - 8'd1;
        b[31] = ~a[31];
      end
      send_pair(a, b);
    end
    in_valid <= 1'b0;
    stall_pct = 0;
    while (pending_sums != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("covered %0d operand pairs, %0d sums checked, under idle and stall phases",
             sent, sums_seen);
    if (fail_count == 0 && pending_sums == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    int held;
    wait (sent >= 1450);
    @(negedge clk);
    held = 0;
    force_hold: while (held < 200) begin
      hold_off = 1'b1;
      @(negedge clk);
      held++;
    end
    hold_off = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/spfa_pkg.sv
hw/rtl/spfa_align.sv
hw/rtl/spfa_arith.sv
hw/rtl/spfa_norm.sv
hw/rtl/single_precision_float_adder_top.sv
tb/sum_checker.sv
tb/testbench.sv
